FILE: sv/mmv_pkg.sv
// Shared types and constants for the modular matrix-vector multiply core.
// No dependencies.
package mmv_pkg;

    localparam int MAX_ROWS  = 64;
    localparam int MAX_COLS  = 128;
    localparam int ELEM_BITS = 16;

    localparam int ROW_IW  = $clog2(MAX_ROWS);         // row index
    localparam int ROW_CW  = $clog2(MAX_ROWS + 1);     // row count
    localparam int COL_IW  = $clog2(MAX_COLS);         // column index
    localparam int COL_CW  = $clog2(MAX_COLS + 1);     // column count
    localparam int MAT_AW  = ROW_IW + COL_IW;
    localparam int MAT_D   = MAX_ROWS * MAX_COLS;
    localparam int PROD_W  = 2 * ELEM_BITS;
    // sum of MAX_COLS products plus one vector entry
    localparam int ACC_W   = PROD_W + COL_IW + 1;
    localparam int BIT_W   = $clog2(ACC_W);
    localparam int MOD_W   = 16;
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    localparam logic [1:0] CFG_MODULUS = 2'd0;
    localparam logic [1:0] CFG_ROWS    = 2'd1;
    localparam logic [1:0] CFG_COLS    = 2'd2;
    localparam logic [1:0] CFG_SYS     = 2'd3;

    typedef enum logic [1:0] {
        ACT_WR_MAT  = 2'd0,
        ACT_WR_VEC  = 2'd1,
        ACT_COMPUTE = 2'd2,
        ACT_NONE    = 2'd3
    } t_action;

    typedef struct packed {
        t_action                action;
        logic [ROW_IW-1:0]      row;
        logic [COL_IW-1:0]      col;
        logic [ELEM_BITS-1:0]   value;
    } t_item;

    typedef struct packed {
        logic [MOD_W-1:0] modulus;
        logic [6:0]       row_count;
        logic [7:0]       col_count;
        logic             sys;
    } t_cfg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROW,
        ST_COLS,
        ST_DRAIN,
        ST_VEC,
        ST_VWAIT,
        ST_MOD,
        ST_EMIT
    } t_state;

endpackage

FILE: sv/mmv_ram.sv
// Generic simple dual-port RAM, one write and one registered read per cycle.
// No dependencies.
module mmv_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: sv/mmv_front.sv
// Front end: accepts transactions, drops unused actions, queues the rest.
// Depends on mmv_pkg.
module mmv_front import mmv_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_item i_item,
    output logic  o_q_valid,
    output t_item o_q_item,
    input  logic  i_q_pop
);
    t_item           r_q [Q_DEPTH];
    logic [Q_AW-1:0] r_wp, r_rp;
    logic [Q_AW:0]   r_cnt;
    logic            push, pop;

    // no transaction is taken while reset is held
    assign o_ready   = i_rst_n && (r_cnt != (Q_AW+1)'(Q_DEPTH));
    assign push      = i_valid && o_ready && (i_item.action != ACT_NONE);
    assign pop       = i_q_pop && (r_cnt != '0);
    assign o_q_valid = (r_cnt != '0);
    assign o_q_item  = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= i_item;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + 1'b1;
            if (pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (Q_AW+1)'(push) - (Q_AW+1)'(pop);
        end
    end
endmodule

FILE: sv/mmv_back.sv
// Back end: stores entries, walks rows and columns, reduces each row sum.
// Depends on mmv_pkg and mmv_ram.
module mmv_back import mmv_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cfg                 i_cfg,
    input  logic                 i_q_valid,
    input  t_item                i_q_item,
    output logic                 o_q_pop,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [MOD_W-1:0]     o_result_value,
    output logic [ROW_IW-1:0]    o_result_row,
    output logic                 o_last
);
    t_state r_state, n_state;

    logic [ROW_CW-1:0]    r_row;
    logic [COL_CW-1:0]    r_col;
    logic                 r_s1, r_s2;
    logic [PROD_W-1:0]    r_prod;
    logic [ACC_W-1:0]     r_acc;
    logic [MOD_W-1:0]     r_rem;
    logic [BIT_W-1:0]     r_bit;
    logic                 r_out_valid;
    logic [MOD_W-1:0]     r_out_value;
    logic [ROW_IW-1:0]    r_out_row;
    logic                 r_out_last;

    logic [ROW_CW-1:0]    rows;
    logic [COL_CW-1:0]    cols, k, ncols;
    logic                 sys, issue, out_free, last_row;
    logic                 mat_we, vec_we;
    logic [MAT_AW-1:0]    mat_raddr;
    logic [COL_IW-1:0]    vec_raddr;
    logic [ELEM_BITS-1:0] mat_rdata, vec_rdata;
    logic [MOD_W:0]       rem2, rem_next;

    assign rows  = (i_cfg.row_count > 7'(MAX_ROWS)) ? ROW_CW'(MAX_ROWS)
                                                    : ROW_CW'(i_cfg.row_count);
    assign cols  = (i_cfg.col_count > 8'(MAX_COLS)) ? COL_CW'(MAX_COLS)
                                                    : COL_CW'(i_cfg.col_count);
    assign sys   = i_cfg.sys && (COL_CW'(rows) <= cols);
    assign k     = cols - COL_CW'(rows);
    assign ncols = sys ? k : cols;
    assign issue = (r_state == ST_COLS) && (r_col < ncols);
    assign out_free = !r_out_valid || i_ready;
    assign last_row = (r_row + 1'b1 == rows);

    assign rem2     = {r_rem, r_acc[ACC_W-1]};
    assign rem_next = (rem2 >= {1'b0, i_cfg.modulus}) ? rem2 - {1'b0, i_cfg.modulus} : rem2;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_q_valid && i_q_item.action == ACT_COMPUTE && rows != '0)
                    n_state = ST_ROW;
            end
            ST_ROW:   n_state = ST_COLS;
            ST_COLS:  if (!issue) n_state = ST_DRAIN;
            ST_DRAIN: if (!r_s1 && !r_s2) n_state = sys ? ST_VEC : ST_MOD;
            ST_VEC:   n_state = ST_VWAIT;
            ST_VWAIT: n_state = ST_MOD;
            ST_MOD:   if (r_bit == '0) n_state = ST_EMIT;
            ST_EMIT:  if (out_free) n_state = last_row ? ST_IDLE : ST_ROW;
            default:  n_state = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        o_q_pop   = (r_state == ST_IDLE) && i_q_valid;
        mat_we    = o_q_pop && (i_q_item.action == ACT_WR_MAT);
        vec_we    = o_q_pop && (i_q_item.action == ACT_WR_VEC);
        mat_raddr = {r_row[ROW_IW-1:0], r_col[COL_IW-1:0]};
        vec_raddr = (r_state == ST_VEC) ? COL_IW'(COL_CW'(r_row) + k)
                                        : r_col[COL_IW-1:0];
    end

    mmv_ram #(.WIDTH(ELEM_BITS), .DEPTH(MAT_D)) u_mat (
        .i_clk   (i_clk),
        .i_we    (mat_we),
        .i_waddr ({i_q_item.row, i_q_item.col}),
        .i_wdata (i_q_item.value),
        .i_raddr (mat_raddr),
        .o_rdata (mat_rdata)
    );

    mmv_ram #(.WIDTH(ELEM_BITS), .DEPTH(MAX_COLS)) u_vec (
        .i_clk   (i_clk),
        .i_we    (vec_we),
        .i_waddr (i_q_item.col),
        .i_wdata (i_q_item.value),
        .i_raddr (vec_raddr),
        .o_rdata (vec_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (r_s1) r_prod <= mat_rdata * vec_rdata;
        unique case (r_state)
            ST_ROW: begin
                r_acc <= '0;
                r_rem <= '0;
                r_bit <= BIT_W'(ACC_W - 1);
            end
            ST_COLS, ST_DRAIN: begin
                if (r_s2) r_acc <= r_acc + ACC_W'(r_prod);
            end
            ST_VWAIT: r_acc <= r_acc + ACC_W'(vec_rdata);
            ST_MOD: begin
                r_rem <= rem_next[MOD_W-1:0];
                r_acc <= r_acc << 1;
                r_bit <= r_bit - 1'b1;
            end
            default: ;
        endcase
        if (r_state == ST_EMIT && out_free) begin
            r_out_value <= (i_cfg.modulus == '0) ? '0 : r_rem;
            r_out_row   <= r_row[ROW_IW-1:0];
            r_out_last  <= last_row;
        end
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_s1        <= 1'b0;
            r_s2        <= 1'b0;
            r_out_valid <= 1'b0;
            r_row       <= '0;
            r_col       <= '0;
        end else begin
            r_state <= n_state;
            r_s1    <= issue;
            r_s2    <= r_s1;
            if (r_state == ST_IDLE) r_row <= '0;
            if (r_state == ST_ROW)  r_col <= '0;
            if (issue) r_col <= r_col + 1'b1;
            if (r_state == ST_EMIT && out_free) begin
                r_out_valid <= 1'b1;
                r_row       <= r_row + 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid        = r_out_valid;
    assign o_result_value = r_out_value;
    assign o_result_row   = r_out_row;
    assign o_last         = r_out_last;
endmodule

FILE: sv/modular_matrix_vector_multiply_core.sv
// Top level of the modular matrix-vector multiply core.
// Depends on mmv_pkg, mmv_front, mmv_back (and mmv_ram through mmv_back).

// Holds a matrix of up to 64 x 128 16-bit entries and a 128-entry vector,
// loaded one entry per transaction (action 0 matrix, 1 vector); action 2
// emits one result per row in use, the row's dot product with the vector
// modulo the modulus, with o_last on the final row; action 3 is dropped.
// In systematic mode (and when rows <= cols) only the first cols - rows
// columns are summed and vector entry row + cols - rows is added. Loads
// are written by the back end while it is idle; a four-deep queue lets
// the input side run ahead. A compute transaction works row by row: a
// column walk (one matrix/vector RAM read per column, registered multiply,
// wide accumulate), in systematic mode one more vector read and add, then
// bit-serial reduction of the unreduced row sum by the modulus, and an
// emit step. Entries read before being written are undefined. Registers:
// 0 modulus, 1 row_count, 2 col_count, 3 systematic_mode; write them only
// while the core is idle.
module modular_matrix_vector_multiply_core import mmv_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // config write port
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_idx,
    input  logic [15:0]          i_cfg_data,
    // input channel
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [1:0]           i_action,
    input  logic [ROW_IW-1:0]    i_row,
    input  logic [COL_IW-1:0]    i_col,
    input  logic [ELEM_BITS-1:0] i_value,
    // result channel
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [MOD_W-1:0]     o_result_value,
    output logic [ROW_IW-1:0]    o_result_row,
    output logic                 o_last
);
    t_cfg  r_cfg;
    t_item in_item, q_item;
    logic  q_valid, q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.modulus   <= 16'd251;
            r_cfg.row_count <= 7'd64;
            r_cfg.col_count <= 8'd128;
            r_cfg.sys       <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MODULUS: r_cfg.modulus   <= i_cfg_data;
                CFG_ROWS:    r_cfg.row_count <= i_cfg_data[6:0];
                CFG_COLS:    r_cfg.col_count <= i_cfg_data[7:0];
                CFG_SYS:     r_cfg.sys       <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign in_item = '{action: t_action'(i_action), row: i_row, col: i_col,
                       value: i_value};

    mmv_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_item    (in_item),
        .o_q_valid (q_valid),
        .o_q_item  (q_item),
        .i_q_pop   (q_pop)
    );

    mmv_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_q_valid      (q_valid),
        .i_q_item       (q_item),
        .o_q_pop        (q_pop),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_result_value (o_result_value),
        .o_result_row   (o_result_row),
        .o_last         (o_last)
    );
endmodule
